// ===== hdl/cptp_pkg.sv =====
// Package: shared codes, character constants and the result type of the coordinate pair parser.
package cptp_pkg;

	localparam int POSITION_WIDTH_DEFAULT    = 16;
	localparam int ACCUMULATOR_WIDTH_DEFAULT = 63;

	// Parser phases.
	localparam logic [2:0] PH_WS1  = 3'd0;
	localparam logic [2:0] PH_DIG1 = 3'd1;
	localparam logic [2:0] PH_WS2  = 3'd2;
	localparam logic [2:0] PH_DIG2 = 3'd3;
	localparam logic [2:0] PH_TAIL = 3'd4;
	localparam logic [2:0] PH_ERR  = 3'd5;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_STRAY    = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	// Characters.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int COLUMN_WIDTH = 16;

	typedef struct packed {
		logic [COLUMN_WIDTH-1:0] error_column;
		logic signed [31:0]      second_value;
		logic signed [31:0]      first_value;
		logic [1:0]              parse_status;
	} cptp_result_t;

endpackage

// ===== hdl/cptp_step.sv =====
// Next-state and result logic for one character of the coordinate pair parser.
module cptp_step #(
	parameter int POSITION_WIDTH    = cptp_pkg::POSITION_WIDTH_DEFAULT,
	parameter int ACCUMULATOR_WIDTH = cptp_pkg::ACCUMULATOR_WIDTH_DEFAULT
) (
	input  logic [7:0]                    text_byte,
	input  logic [2:0]                    phase,
	input  logic [ACCUMULATOR_WIDTH-1:0]  acc,
	input  logic                          neg,
	input  logic [31:0]                   first,
	input  logic [POSITION_WIDTH-1:0]     pos,
	input  logic [1:0]                    err,
	input  logic [15:0]                   err_col,
	output logic [2:0]                    phase_n,
	output logic [ACCUMULATOR_WIDTH-1:0]  acc_n,
	output logic                          neg_n,
	output logic [31:0]                   first_n,
	output logic [POSITION_WIDTH-1:0]     pos_n,
	output logic [1:0]                    err_n,
	output logic [15:0]                   err_col_n,
	output cptp_pkg::cptp_result_t        result
);

	localparam int PW = ACCUMULATOR_WIDTH + 4;

	logic          is_space;
	logic          is_digit;
	logic          is_sign;
	logic          is_minus;
	logic          is_end;
	logic [PW-1:0] acc_ext;
	logic [PW-1:0] prod;
	logic          ovf;
	logic [31:0]   cur_low;
	logic [POSITION_WIDTH-1:0] pos_inc;
	logic [31:0]   pos_wide;
	logic [15:0]   stray_col;

	assign is_space = (text_byte == cptp_pkg::CH_SPACE) || (text_byte == cptp_pkg::CH_FF) ||
		(text_byte == cptp_pkg::CH_TAB) || (text_byte == cptp_pkg::CH_LF) ||
		(text_byte == cptp_pkg::CH_CR) || (text_byte == cptp_pkg::CH_VT);
	assign is_digit = (text_byte >= cptp_pkg::CH_ZERO) && (text_byte <= cptp_pkg::CH_NINE);
	assign is_minus = (text_byte == cptp_pkg::CH_MINUS);
	assign is_sign  = is_minus || (text_byte == cptp_pkg::CH_PLUS);
	assign is_end   = (text_byte == cptp_pkg::CH_NUL);

	// The accumulator is zero in both whitespace phases, so one multiply-by-ten
	// unit serves every place a digit can land.
	assign acc_ext = PW'(acc);
	assign prod    = (acc_ext << 3) + (acc_ext << 1) + PW'(text_byte[3:0]);
	assign ovf     = |prod[PW-1:ACCUMULATOR_WIDTH];

	assign cur_low = neg ? (32'd0 - acc[31:0]) : acc[31:0];

	assign pos_inc   = (pos == {POSITION_WIDTH{1'b1}}) ? pos : pos + POSITION_WIDTH'(1);
	assign pos_wide  = 32'(pos_inc);
	assign stray_col = (pos_wide > 32'h0000_FFFF) ? 16'hFFFF : pos_wide[15:0];

	always_comb begin
		phase_n   = phase;
		acc_n     = acc;
		neg_n     = neg;
		first_n   = first;
		pos_n     = pos;
		err_n     = err;
		err_col_n = err_col;
		result    = '0;

		if (!is_end) begin
			pos_n = pos_inc;
			unique case (phase) inside
				cptp_pkg::PH_WS1, cptp_pkg::PH_WS2, cptp_pkg::PH_DIG1,
				cptp_pkg::PH_DIG2: begin
					if (is_digit) begin
						if (ovf) begin
							err_n     = cptp_pkg::ST_OVERFLOW;
							err_col_n = '0;
							phase_n   = cptp_pkg::PH_ERR;
						end else begin
							acc_n   = prod[ACCUMULATOR_WIDTH-1:0];
							phase_n = (phase == cptp_pkg::PH_WS1 || phase == cptp_pkg::PH_DIG1) ?
								cptp_pkg::PH_DIG1 : cptp_pkg::PH_DIG2;
						end
					end else if (phase == cptp_pkg::PH_DIG2) begin
						if (is_space) begin
							phase_n = cptp_pkg::PH_TAIL;
						end else begin
							err_n     = cptp_pkg::ST_STRAY;
							err_col_n = stray_col;
							phase_n   = cptp_pkg::PH_ERR;
						end
					end else if (phase == cptp_pkg::PH_WS1 && is_space) begin
						phase_n = phase;
					end else if (phase == cptp_pkg::PH_WS1 && is_sign) begin
						neg_n   = is_minus;
						phase_n = cptp_pkg::PH_DIG1;
					end else if (phase == cptp_pkg::PH_WS2) begin
						if (is_sign) begin
							neg_n   = is_minus;
							phase_n = cptp_pkg::PH_DIG2;
						end else if (!is_space) begin
							err_n     = cptp_pkg::ST_STRAY;
							err_col_n = stray_col;
							phase_n   = cptp_pkg::PH_ERR;
						end
					end else begin
						// A non-digit closes the first number and is then taken as the
						// start of the second one.
						first_n = cur_low;
						acc_n   = '0;
						neg_n   = 1'b0;
						if (is_space) begin
							phase_n = cptp_pkg::PH_WS2;
						end else if (is_sign) begin
							neg_n   = is_minus;
							phase_n = cptp_pkg::PH_DIG2;
						end else begin
							err_n     = cptp_pkg::ST_STRAY;
							err_col_n = stray_col;
							phase_n   = cptp_pkg::PH_ERR;
						end
					end
				end
				cptp_pkg::PH_TAIL: begin
					if (!is_space) begin
						err_n     = cptp_pkg::ST_STRAY;
						err_col_n = stray_col;
						phase_n   = cptp_pkg::PH_ERR;
					end
				end
				default: begin
					phase_n = phase;
				end
			endcase
		end else begin
			if (pos == '0) begin
				result.parse_status = cptp_pkg::ST_EMPTY;
			end else begin
				result.parse_status = err;
				if (err == cptp_pkg::ST_OK) begin
					if (phase == cptp_pkg::PH_WS1 || phase == cptp_pkg::PH_DIG1) begin
						result.first_value = cur_low;
					end else begin
						result.first_value  = first;
						result.second_value = cur_low;
					end
				end else if (err == cptp_pkg::ST_STRAY) begin
					result.error_column = err_col;
				end
			end
			phase_n   = cptp_pkg::PH_WS1;
			acc_n     = '0;
			neg_n     = 1'b0;
			first_n   = '0;
			pos_n     = '0;
			err_n     = cptp_pkg::ST_OK;
			err_col_n = '0;
		end
	end

endmodule

// ===== hdl/coordinate_pair_text_parser_core.sv =====
// Top level of the coordinate pair text parser: stream ports, state registers, output register.
//
// Channel  Direction  Word                        tdata bits (low to high)
// s_*      in         one character of a line      text_byte[7:0]
// m_*      out        one result per line          status, first, second, column
//
// One character is accepted per cycle. A character goes to an input register, and
// one level of logic (a multiply by ten and a compare) updates the parse state from it.
// Only the end character of a line produces a word, registered in the output register as it leaves the input register.
// An end character waits in the input register while an earlier result is not taken;
// other characters never wait there. Reset returns the parser to the start of a line.
module coordinate_pair_text_parser_core #(
	parameter int POSITION_WIDTH    = cptp_pkg::POSITION_WIDTH_DEFAULT,
	parameter int ACCUMULATOR_WIDTH = cptp_pkg::ACCUMULATOR_WIDTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] text_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata   // [1:0] parse_status, [33:2] first_value,
	                              // [65:34] second_value, [81:66] error_column, rest zero
);

	logic [7:0]                   byte_s1;
	logic                         valid_s1;
	logic                         end_s1;
	logic                         take_s1;

	logic [2:0]                   phase_q;
	logic [ACCUMULATOR_WIDTH-1:0] acc_q;
	logic                         neg_q;
	logic [31:0]                  first_q;
	logic [POSITION_WIDTH-1:0]    pos_q;
	logic [1:0]                   err_q;
	logic [15:0]                  err_col_q;

	logic [2:0]                   phase_n;
	logic [ACCUMULATOR_WIDTH-1:0] acc_n;
	logic                         neg_n;
	logic [31:0]                  first_n;
	logic [POSITION_WIDTH-1:0]    pos_n;
	logic [1:0]                   err_n;
	logic [15:0]                  err_col_n;
	cptp_pkg::cptp_result_t       result;

	logic                         out_valid_q;
	cptp_pkg::cptp_result_t       out_q;

	assign end_s1   = (byte_s1 == cptp_pkg::CH_NUL);
	assign take_s1  = valid_s1 && (!end_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || take_s1;

	cptp_step #(
		.POSITION_WIDTH    (POSITION_WIDTH),
		.ACCUMULATOR_WIDTH (ACCUMULATOR_WIDTH)
	) u_step (
		.text_byte (byte_s1),
		.phase     (phase_q),
		.acc       (acc_q),
		.neg       (neg_q),
		.first     (first_q),
		.pos       (pos_q),
		.err       (err_q),
		.err_col   (err_col_q),
		.phase_n   (phase_n),
		.acc_n     (acc_n),
		.neg_n     (neg_n),
		.first_n   (first_n),
		.pos_n     (pos_n),
		.err_n     (err_n),
		.err_col_n (err_col_n),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= cptp_pkg::PH_WS1;
			acc_q     <= '0;
			neg_q     <= 1'b0;
			first_q   <= '0;
			pos_q     <= '0;
			err_q     <= cptp_pkg::ST_OK;
			err_col_q <= '0;
		end else if (take_s1) begin
			phase_q   <= phase_n;
			acc_q     <= acc_n;
			neg_q     <= neg_n;
			first_q   <= first_n;
			pos_q     <= pos_n;
			err_q     <= err_n;
			err_col_q <= err_col_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s1 && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && end_s1) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q};

endmodule

// ===== test/cptp_result_checker.sv =====
`timescale 1ns / 100ps
// Checker for the coordinate pair parser: predicts every line result and compares the output words.
module cptp_result_checker
	import cptp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,
	output int          error_count,
	output int          pending
);

	localparam longint unsigned MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	// Predicted parser state for the line in progress.
	logic [2:0]      scan_state;
	longint unsigned digit_mag;
	bit              minus;
	logic [31:0]     abscissa;
	logic [15:0]     char_count;
	logic [1:0]      first_error;
	logic [15:0]     stray_col;

	cptp_result_t expected_lines[$];
	int           words_seen;

	function automatic bit is_blank(logic [7:0] c);
		return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
	endfunction

	function automatic bit is_numeral(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic [31:0] signed_low_word();
		longint unsigned v;
		v = minus ? (64'd0 - digit_mag) : digit_mag;
		return v[31:0];
	endfunction

	function automatic void start_line();
		scan_state  = PH_WS1;
		digit_mag   = 0;
		minus       = 0;
		abscissa    = '0;
		char_count  = '0;
		first_error = ST_OK;
		stray_col   = '0;
	endfunction

	function automatic void take_digit(logic [7:0] c);
		longint unsigned d;
		d = 64'(c - CH_ZERO);
		if (digit_mag > (MAG_MAX - d) / 10) begin
			first_error = ST_OVERFLOW;
			stray_col   = '0;
			scan_state  = PH_ERR;
		end else begin
			digit_mag = digit_mag * 10 + d;
		end
	endfunction

	// A character that ends a number is looked at again in the following phase.
	function automatic void scan_char(logic [7:0] c);
		bit again;
		again = 1;
		while (again) begin
			again = 0;
			case (scan_state)
				PH_WS1, PH_WS2: begin
					if (!is_blank(c)) begin
						scan_state = (scan_state == PH_WS1) ? PH_DIG1 : PH_DIG2;
						if (c == CH_PLUS || c == CH_MINUS)
							minus = (c == CH_MINUS);
						else
							again = 1;
					end
				end
				PH_DIG1: begin
					if (is_numeral(c)) begin
						take_digit(c);
					end else begin
						abscissa   = signed_low_word();
						digit_mag  = 0;
						minus      = 0;
						scan_state = PH_WS2;
						again      = 1;
					end
				end
				PH_DIG2: begin
					if (is_numeral(c)) begin
						take_digit(c);
					end else begin
						scan_state = PH_TAIL;
						again      = 1;
					end
				end
				PH_TAIL: begin
					if (c != CH_NUL && !is_blank(c)) begin
						first_error = ST_STRAY;
						stray_col   = char_count;
						scan_state  = PH_ERR;
					end
				end
				default: ;
			endcase
		end
	endfunction

	function automatic void predict_char(logic [7:0] c);
		cptp_result_t want;
		if (c != CH_NUL) begin
			if (char_count != 16'hFFFF)
				char_count++;
			scan_char(c);
		end else begin
			want = '0;
			if (char_count == 0) begin
				want.parse_status = ST_EMPTY;
			end else begin
				scan_char(CH_NUL);
				want.parse_status = first_error;
				if (first_error == ST_OK) begin
					want.first_value  = abscissa;
					want.second_value = signed_low_word();
				end else if (first_error == ST_STRAY) begin
					want.error_column = stray_col;
				end
			end
			expected_lines.push_back(want);
			start_line();
		end
	endfunction

	initial begin
		start_line();
		error_count = 0;
		pending     = 0;
		words_seen  = 0;
	end

	always @(posedge clk) begin : watch
		cptp_result_t got;
		cptp_result_t want;
		if (arst_n) begin
			// The result word is compared before the character of this edge is predicted.
			if (m_tvalid && m_tready) begin
				got = m_tdata[81:0];
				if (expected_lines.size() == 0) begin
					if (error_count < 10)
						$display("unexpected result word %0d: status %0d first %0d second %0d column %0d",
							words_seen, got.parse_status, got.first_value, got.second_value,
							got.error_column);
					error_count++;
				end else begin
					want = expected_lines.pop_front();
					if (got !== want || m_tdata[87:82] !== 6'd0) begin
						// Fields are listed as status, first, second, column.
						if (error_count < 10)
							$display("mismatch at word %0d: expected %0d %0d %0d %0d got %0d %0d %0d %0d pad %h",
								words_seen, want.parse_status, want.first_value, want.second_value,
								want.error_column, got.parse_status, got.first_value,
								got.second_value, got.error_column, m_tdata[87:82]);
						error_count++;
					end
				end
				words_seen++;
			end
			if (s_tvalid && s_tready)
				predict_char(s_tdata);
			pending = expected_lines.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the coordinate pair parser: clock, reset, line stimulus, output stalls and verdict.
module tb_top;
	import cptp_pkg::*;

	typedef logic [7:0] text_q_t[$];

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_CHARS = 1100;
	localparam int HOLD_CYCLES  = 400;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;

	int error_count;
	int pending;
	int cycles = 0;
	bit hold_off = 0;
	bit holding = 0;

	coordinate_pair_text_parser_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	cptp_result_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.error_count(error_count),
		.pending    (pending)
	);

	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		arst_n   = 0;
		s_tvalid = 0;
		s_tdata  = '0;
		m_tready = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_VT;
			4: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic void add_blanks(ref text_q_t q, input int most);
		int n;
		n = $urandom_range(0, most);
		repeat (n) q.push_back(pick_blank());
	endfunction

	function automatic void add_text(ref text_q_t q, input string s);
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
	endfunction

	// An optional sign, then a digit run: mostly short, sometimes empty or near the overflow boundary.
	function automatic void add_number(ref text_q_t q);
		int r;
		int n;
		case ($urandom_range(0, 2))
			0: q.push_back(CH_PLUS);
			1: q.push_back(CH_MINUS);
			default: ;
		endcase
		r = $urandom_range(0, 99);
		if (r < 6) begin
			n = 0;
		end else if (r < 12) begin
			add_text(q, $urandom_range(0, 1) ? "9223372036854775807" : "9223372036854775808");
			n = 0;
		end else if (r < 20) begin
			n = $urandom_range(18, 22);
		end else begin
			n = $urandom_range(1, 10);
		end
		repeat (n) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	function automatic text_q_t random_line();
		text_q_t q;
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 4) begin
			// empty line
		end else if (r < 18) begin
			n = $urandom_range(1, 16);
			repeat (n) q.push_back(8'($urandom_range(1, 255)));
		end else begin
			add_blanks(q, 3);
			add_number(q);
			add_blanks(q, $urandom_range(0, 1) ? 3 : 0);
			add_number(q);
			add_blanks(q, 3);
			if ($urandom_range(0, 9) == 0)
				q.push_back(8'($urandom_range(1, 255)));
			if ($urandom_range(0, 19) == 0 && q.size() > 0)
				q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(1, 255));
			add_blanks(q, 2);
		end
		q.push_back(CH_NUL);
		return q;
	endfunction

	// Valid stays high from one word to the next unless a gap follows.
	task automatic send_line(input text_q_t q, input bit no_gaps);
		int gap;
		foreach (q[i]) begin
			s_tvalid <= 1;
			s_tdata  <= q[i];
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			gap = no_gaps ? 0 : pick_gap();
			if (gap > 0) begin
				s_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_text(input string s);
		text_q_t q;
		add_text(q, s);
		q.push_back(CH_NUL);
		send_line(q, 0);
	endtask

	// Receiver: random stalls, long ready stretches, and one long hold-off on request.
	initial begin : receiver
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off) begin
				m_tready <= 0;
				holding = 1;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding  = 0;
				hold_off = 0;
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					m_tready <= 0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1;
			repeat ($urandom_range(0, 99) < 10 ? $urandom_range(100, 300) : $urandom_range(1, 12))
				@(posedge clk);
		end
	end

	initial begin : stimulus
		string    directed_lines[];
		text_q_t  line;
		int       sent;
		bit       held;
		directed_lines = '{
			"", "1 2", "-0 +0", "-2147483648 2147483647", "4294967296 -4294967297",
			"9223372036854775807 -9223372036854775807", "-9223372036854775808 1",
			"1 -92233720368547758070", "1-2", "+-", "-", "7", "   ", "12 34 x", "3 4 5",
			"abc", "x 9", "99999999999999999999999 x", "\t-15\t+16\t"
		};
		wait (arst_n);
		@(posedge clk);

		foreach (directed_lines[i])
			send_text(directed_lines[i]);

		// Every blank character between and around the numbers.
		line = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, "5", CH_CR, CH_VT, "-", "6",
			CH_FF, CH_LF, CH_NUL};
		send_line(line, 0);
		// A stray character with the top bit set.
		line = '{"1", CH_SPACE, "2", CH_SPACE, 8'hFF, 8'h80, CH_NUL};
		send_line(line, 0);

		send_text("8 9");

		sent = 0;
		held = 0;
		while (sent < RANDOM_CHARS) begin
			if (!held && sent > 400) begin
				// Keep offering short lines while the output is held off, so the input stalls.
				hold_off = 1;
				wait (holding);
				repeat (40) begin
					line = '{"4", CH_NUL};
					send_line(line, 1);
				end
				held = 1;
				sent += 80;
			end
			line = random_line();
			send_line(line, $urandom_range(0, 4) == 0);
			sent += line.size();
		end
		s_tvalid <= 0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
